FILE: rtl/euler_point_rotation_assert.svh
// ----------------------------------------------------------------------------
// Euler point rotation assertion macros
// Shared property wrappers for the checker, clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef EULER_POINT_ROTATION_ASSERT_SVH
`define EULER_POINT_ROTATION_ASSERT_SVH

// Antecedent implies consequent in the same cycle
`define EPR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("epr assertion failed");

// Antecedent implies consequent in the next cycle
`define EPR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("epr assertion failed");

`endif

FILE: rtl/epr_pkg.sv
// ----------------------------------------------------------------------------
// Euler point rotation package
// Defaults, register indexes, trig constants and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package epr_pkg;

    localparam int COORD_WIDTH_DEF    = 32;
    localparam int ANGLE_WIDTH_DEF    = 16;
    localparam int TRIG_FRAC_BITS_DEF = 16;

    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PIVOT_X = 3'd0,
        REG_PIVOT_Y = 3'd1,
        REG_PIVOT_Z = 3'd2,
        REG_ROLL    = 3'd3,
        REG_PITCH   = 3'd4,
        REG_YAW     = 3'd5
    } reg_idx_t;

    // pi/2 in unsigned Q32 and one in Q32
    localparam logic [32:0] PIO2_Q32 = 33'd6746518852;
    localparam logic [32:0] Q32_ONE  = 33'h1_0000_0000;

    localparam int SIN_STEPS = 5;
    localparam int COS_STEPS = 6;

    // Reciprocal of k for a shift of sh: ceil(2^sh / k)
    function automatic logic [32:0] rcp_const(input int k, input int sh);
        logic [64:0] num;
        begin
            num = (65'(1) << sh) + 65'(k - 1);
            return 33'(num / 65'(k));
        end
    endfunction

    // Horner divisors as reciprocals: floor(n / k) = (n * RCP) >> (32 + SH)
    // for any n below 2^32, with SH = ceil(log2(k))
    localparam logic [32:0] RCP_110 = rcp_const(110, 39);
    localparam logic [32:0] RCP_72  = rcp_const(72, 39);
    localparam logic [32:0] RCP_42  = rcp_const(42, 38);
    localparam logic [32:0] RCP_20  = rcp_const(20, 37);
    localparam logic [32:0] RCP_6   = rcp_const(6, 35);
    localparam logic [32:0] RCP_132 = rcp_const(132, 40);
    localparam logic [32:0] RCP_90  = rcp_const(90, 39);
    localparam logic [32:0] RCP_56  = rcp_const(56, 38);
    localparam logic [32:0] RCP_30  = rcp_const(30, 37);
    localparam logic [32:0] RCP_12  = rcp_const(12, 36);
    localparam logic [32:0] RCP_2   = rcp_const(2, 33);

    // Reciprocal of the Horner divisor, sine and cosine series
    function automatic logic [32:0] horner_rcp(input logic cos_phase,
                                               input logic [2:0] step);
        logic [32:0] m;
        begin
            m = '0;
            if (!cos_phase)
            begin
                case (step)
                    3'd0:    m = RCP_110;
                    3'd1:    m = RCP_72;
                    3'd2:    m = RCP_42;
                    3'd3:    m = RCP_20;
                    3'd4:    m = RCP_6;
                    default: m = '0;
                endcase
            end
            else
            begin
                case (step)
                    3'd0:    m = RCP_132;
                    3'd1:    m = RCP_90;
                    3'd2:    m = RCP_56;
                    3'd3:    m = RCP_30;
                    3'd4:    m = RCP_12;
                    3'd5:    m = RCP_2;
                    default: m = '0;
                endcase
            end
            return m;
        end
    endfunction

    // Extra shift beyond 32 that goes with each reciprocal
    function automatic logic [3:0] horner_sh(input logic cos_phase,
                                             input logic [2:0] step);
        logic [3:0] sh;
        begin
            sh = 4'd0;
            if (!cos_phase)
            begin
                case (step)
                    3'd0:    sh = 4'd7;
                    3'd1:    sh = 4'd7;
                    3'd2:    sh = 4'd6;
                    3'd3:    sh = 4'd5;
                    3'd4:    sh = 4'd3;
                    default: sh = 4'd0;
                endcase
            end
            else
            begin
                case (step)
                    3'd0:    sh = 4'd8;
                    3'd1:    sh = 4'd7;
                    3'd2:    sh = 4'd6;
                    3'd3:    sh = 4'd5;
                    3'd4:    sh = 4'd4;
                    3'd5:    sh = 4'd1;
                    default: sh = 4'd0;
                endcase
            end
            return sh;
        end
    endfunction

    typedef enum logic [10:0] {
        TS_IDLE   = 11'b000_0000_0001,
        TS_LOAD   = 11'b000_0000_0010,
        TS_XSAVE  = 11'b000_0000_0100,
        TS_X2MUL  = 11'b000_0000_1000,
        TS_X2SAVE = 11'b000_0001_0000,
        TS_HMUL   = 11'b000_0010_0000,
        TS_HPRE   = 11'b000_0100_0000,
        TS_HDIV   = 11'b000_1000_0000,
        TS_SMUL   = 11'b001_0000_0000,
        TS_SSAVE  = 11'b010_0000_0000,
        TS_STORE  = 11'b100_0000_0000
    } trig_state_t;

endpackage

`default_nettype wire

FILE: rtl/euler_point_rotation.sv
// ----------------------------------------------------------------------------
// Euler point rotation
// Rotates a Q16.16 point about a pivot by yaw, pitch and roll.
//
//   channel   dir  handshake                 payload
//   s_axis    in   s_axis_tvalid/tready      point_x, point_y, point_z
//   m_axis    out  m_axis_tvalid/tready      rotated_x, rotated_y, rotated_z
//   cfg       in   cfg_we                    cfg_addr, cfg_data
//
// One point per cycle while neither backpressure nor the trig sequencer holds
// the input; stages are pivot subtract, three rotations of two stages each,
// pivot add and clamp. Every stage holds its item under backpressure and
// takes a new one as soon as its own slot frees. An angle write starts the
// trig sequencer (multiply, reciprocal multiply and shift for each of eleven
// series terms per angle), with input held off until it is done.
// Reset clears valid bits, pivot and angle registers to zero, sine 0 and cosine 1.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_point_rotation
    import epr_pkg::*;
#(
    parameter int COORD_WIDTH    = COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH    = ANGLE_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
    localparam int TD_W  = ((3 * COORD_WIDTH + 7) / 8) * 8,
    localparam int CFG_W = (COORD_WIDTH > ANGLE_WIDTH) ? COORD_WIDTH : ANGLE_WIDTH
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [TD_W-1:0]        s_axis_tdata,   // point_x, point_y, point_z
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [TD_W-1:0]             m_axis_tdata,   // rotated_x, rotated_y, rotated_z
    input  wire logic                   cfg_we,
    input  wire logic [REG_IDX_W-1:0]   cfg_addr,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    localparam int CW = COORD_WIDTH;
    localparam int TW = TRIG_FRAC_BITS + 2;
    localparam int D0 = CW + 1;
    localparam int D1 = D0 + 1;
    localparam int D2 = D1 + 1;
    localparam int D3 = D2 + 1;
    localparam int SW = D3 + 1;
    localparam logic signed [SW-1:0] SAT_HI = SW'({1'b0, {(CW-1){1'b1}}});
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic signed [CW-1:0] pivot_x_reg;
    logic signed [CW-1:0] pivot_y_reg;
    logic signed [CW-1:0] pivot_z_reg;

    logic                 trig_ready;
    logic signed [TW-1:0] yaw_sin, yaw_cos, pitch_sin, pitch_cos, roll_sin, roll_cos;
    logic signed [TW-1:0] pitch_sin_neg;

    logic                 v0_reg;
    logic                 adv0;
    logic signed [D0-1:0] dx_reg, dy_reg, dz_reg;

    logic                 yaw_in_ready, yaw_valid, pitch_in_ready, pitch_valid;
    logic                 roll_in_ready, roll_valid;
    logic signed [D1-1:0] yx, yy, yz;
    logic signed [D2-1:0] px, pz, py;
    logic signed [D3-1:0] ry, rz, rx;

    logic                 vo_reg;
    logic                 advo;
    logic [CW-1:0]        ox_reg, oy_reg, oz_reg;

    function automatic logic [CW-1:0] clamp(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        begin
            r = v;
            if (v > SAT_HI)
                r = SAT_HI;
            else if (v < SAT_LO)
                r = SAT_LO;
            return r[CW-1:0];
        end
    endfunction

    // Pivot registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_x_reg <= '0;
            pivot_y_reg <= '0;
            pivot_z_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_PIVOT_X: pivot_x_reg <= cfg_data[CW-1:0];
                REG_PIVOT_Y: pivot_y_reg <= cfg_data[CW-1:0];
                REG_PIVOT_Z: pivot_z_reg <= cfg_data[CW-1:0];
                default:     ;
            endcase
        end
    end

    epr_trig #(
        .ANGLE_WIDTH    (ANGLE_WIDTH),
        .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
        .CFG_W          (CFG_W)
    ) u_trig (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_data   (cfg_data),
        .trig_ready (trig_ready),
        .yaw_sin    (yaw_sin),
        .yaw_cos    (yaw_cos),
        .pitch_sin  (pitch_sin),
        .pitch_cos  (pitch_cos),
        .roll_sin   (roll_sin),
        .roll_cos   (roll_cos)
    );

    // Subtract pivot
    assign adv0          = !v0_reg || yaw_in_ready;
    assign s_axis_tready = adv0 && trig_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v0_reg <= 1'b0;
        else if (adv0)
            v0_reg <= s_axis_tvalid && trig_ready;
    end

    always_ff @(posedge clk)
    begin
        if (adv0)
        begin
            dx_reg <= D0'($signed(s_axis_tdata[0 +: CW]))    - D0'(pivot_x_reg);
            dy_reg <= D0'($signed(s_axis_tdata[CW +: CW]))   - D0'(pivot_y_reg);
            dz_reg <= D0'($signed(s_axis_tdata[2*CW +: CW])) - D0'(pivot_z_reg);
        end
    end

    // Yaw about z on (x, y)
    epr_rotate #(.IN_W(D0), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_yaw (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v0_reg),
        .in_ready  (yaw_in_ready),
        .in_u      (dx_reg),
        .in_v      (dy_reg),
        .in_w      (dz_reg),
        .sn        (yaw_sin),
        .cs        (yaw_cos),
        .out_valid (yaw_valid),
        .out_ready (pitch_in_ready),
        .out_a     (yx),
        .out_b     (yy),
        .out_w     (yz)
    );

    // Pitch about y on (x, z), sine sense flipped
    assign pitch_sin_neg = -pitch_sin;

    epr_rotate #(.IN_W(D1), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (yaw_valid),
        .in_ready  (pitch_in_ready),
        .in_u      (yx),
        .in_v      (yz),
        .in_w      (yy),
        .sn        (pitch_sin_neg),
        .cs        (pitch_cos),
        .out_valid (pitch_valid),
        .out_ready (roll_in_ready),
        .out_a     (px),
        .out_b     (pz),
        .out_w     (py)
    );

    // Roll about x on (y, z)
    epr_rotate #(.IN_W(D2), .TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pitch_valid),
        .in_ready  (roll_in_ready),
        .in_u      (py),
        .in_v      (pz),
        .in_w      (px),
        .sn        (roll_sin),
        .cs        (roll_cos),
        .out_valid (roll_valid),
        .out_ready (advo),
        .out_a     (ry),
        .out_b     (rz),
        .out_w     (rx)
    );

    // Add pivot back, clamp, hold for the consumer
    assign advo = !vo_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vo_reg <= 1'b0;
        else if (advo)
            vo_reg <= roll_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advo)
        begin
            ox_reg <= clamp(SW'(rx) + SW'(pivot_x_reg));
            oy_reg <= clamp(SW'(ry) + SW'(pivot_y_reg));
            oz_reg <= clamp(SW'(rz) + SW'(pivot_z_reg));
        end
    end

    assign m_axis_tvalid = vo_reg;

    always_comb
    begin
        m_axis_tdata            = '0;
        m_axis_tdata[3*CW-1:0]  = {oz_reg, oy_reg, ox_reg};
    end

endmodule

`default_nettype wire

FILE: rtl/epr_trig.sv
// ----------------------------------------------------------------------------
// Euler point rotation trig sequencer
// Holds the three angles and recomputes sine and cosine after an angle write
// with one shared multiplier; each divide by a small series constant is a
// reciprocal multiply followed by a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module epr_trig
    import epr_pkg::*;
#(
    parameter int ANGLE_WIDTH    = ANGLE_WIDTH_DEF,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
    parameter int CFG_W          = COORD_WIDTH_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [REG_IDX_W-1:0]               cfg_addr,
    input  wire logic [CFG_W-1:0]                   cfg_data,
    output logic                                    trig_ready,
    output logic signed [TRIG_FRAC_BITS+1:0]        yaw_sin,
    output logic signed [TRIG_FRAC_BITS+1:0]        yaw_cos,
    output logic signed [TRIG_FRAC_BITS+1:0]        pitch_sin,
    output logic signed [TRIG_FRAC_BITS+1:0]        pitch_cos,
    output logic signed [TRIG_FRAC_BITS+1:0]        roll_sin,
    output logic signed [TRIG_FRAC_BITS+1:0]        roll_cos
);

    localparam int A  = ANGLE_WIDTH;
    localparam int F  = TRIG_FRAC_BITS;
    localparam int TW = F + 2;
    localparam int RW = A - 2;
    localparam logic [RW:0]   QUAD = (RW+1)'(1) << RW;
    localparam logic [RW-1:0] HALF = RW'(1) << (RW - 1);
    localparam logic signed [TW-1:0] ONE_TRIG = TW'(1) << F;

    trig_state_t state_reg, state_next;

    logic [A-1:0]   angle_reg [3];
    logic           dirty_reg;
    logic [1:0]     idx_reg;
    logic [1:0]     q_reg;
    logic           swap_reg;
    logic [31:0]    x_reg;
    logic [31:0]    x2_reg;
    logic [32:0]    t_reg;
    logic [31:0]    sv_reg;
    logic [65:0]    prod_reg;
    logic [2:0]     step_reg;
    logic           cos_phase_reg;
    logic signed [TW-1:0] sin_reg [3];
    logic signed [TW-1:0] cos_reg [3];

    logic           angle_we;
    logic [A-1:0]   ang;
    logic [RW-1:0]  r_raw;
    logic           swap_c;
    logic [RW-1:0]  r_red;
    logic [32:0]    mul_a;
    logic [32:0]    mul_b;
    logic [65:0]    mul_p;
    logic [32:0]    rcp_cur;
    logic [3:0]     sh_cur;
    logic [33:0]    prod_hi;
    logic [31:0]    quot;
    logic           last_step;
    logic signed [TW-1:0] s_val;
    logic signed [TW-1:0] c_val;
    logic signed [TW-1:0] sn_out;
    logic signed [TW-1:0] cs_out;

    function automatic logic signed [TW-1:0] trig_round(input logic [32:0] v);
        logic [33:0] tmp;
        begin
            tmp = {1'b0, v} + (34'(1) << (31 - F));
            return TW'(tmp >> (32 - F));
        end
    endfunction

    assign angle_we = cfg_we && ((cfg_addr == REG_ROLL) || (cfg_addr == REG_PITCH)
                                 || (cfg_addr == REG_YAW));

    // Reduce the selected angle to one eighth of a turn
    assign ang    = angle_reg[idx_reg];
    assign r_raw  = ang[RW-1:0];
    assign swap_c = r_raw > HALF;
    assign r_red  = swap_c ? RW'(QUAD - {1'b0, r_raw}) : r_raw;

    // Reciprocal and shift of the current Horner divisor
    assign rcp_cur   = horner_rcp(cos_phase_reg, step_reg);
    assign sh_cur    = horner_sh(cos_phase_reg, step_reg);
    assign prod_hi   = prod_reg[65:32];
    assign quot      = 32'(prod_hi >> sh_cur);
    assign last_step = cos_phase_reg ? (step_reg == 3'(COS_STEPS - 1))
                                     : (step_reg == 3'(SIN_STEPS - 1));

    // Share one multiplier across the sequence
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            TS_LOAD:
            begin
                mul_a = 33'(r_red);
                mul_b = PIO2_Q32;
            end
            TS_X2MUL:
            begin
                mul_a = {1'b0, x_reg};
                mul_b = {1'b0, x_reg};
            end
            TS_HMUL:
            begin
                mul_a = {1'b0, x2_reg};
                mul_b = t_reg;
            end
            TS_HPRE:
            begin
                mul_a = {1'b0, prod_reg[32 +: 32]};
                mul_b = rcp_cur;
            end
            TS_SMUL:
            begin
                mul_a = {1'b0, x_reg};
                mul_b = t_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Round, undo the swap and apply the quadrant
    always_comb
    begin
        s_val = trig_round(swap_reg ? t_reg : {1'b0, sv_reg});
        c_val = trig_round(swap_reg ? {1'b0, sv_reg} : t_reg);
        case (q_reg)
            2'd0:
            begin
                sn_out = s_val;
                cs_out = c_val;
            end
            2'd1:
            begin
                sn_out = c_val;
                cs_out = -s_val;
            end
            2'd2:
            begin
                sn_out = -s_val;
                cs_out = -c_val;
            end
            default:
            begin
                sn_out = -c_val;
                cs_out = s_val;
            end
        endcase
    end

    // Sequence the series evaluation
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            TS_IDLE:   if (dirty_reg) state_next = TS_LOAD;
            TS_LOAD:   state_next = TS_XSAVE;
            TS_XSAVE:  state_next = TS_X2MUL;
            TS_X2MUL:  state_next = TS_X2SAVE;
            TS_X2SAVE: state_next = TS_HMUL;
            TS_HMUL:   state_next = TS_HPRE;
            TS_HPRE:   state_next = TS_HDIV;
            TS_HDIV:
            begin
                if (!last_step)
                    state_next = TS_HMUL;
                else if (cos_phase_reg)
                    state_next = TS_STORE;
                else
                    state_next = TS_SMUL;
            end
            TS_SMUL:   state_next = TS_SSAVE;
            TS_SSAVE:  state_next = TS_HMUL;
            TS_STORE:  state_next = (idx_reg == 2'd2) ? TS_IDLE : TS_LOAD;
            default:   state_next = TS_IDLE;
        endcase
    end

    // Control state, angles and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= TS_IDLE;
            dirty_reg     <= 1'b0;
            idx_reg       <= '0;
            step_reg      <= '0;
            cos_phase_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                angle_reg[i] <= '0;
                sin_reg[i]   <= '0;
                cos_reg[i]   <= ONE_TRIG;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (angle_we)
                dirty_reg <= 1'b1;
            else if (state_reg == TS_IDLE)
                dirty_reg <= 1'b0;

            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_YAW:   angle_reg[0] <= cfg_data[A-1:0];
                    REG_PITCH: angle_reg[1] <= cfg_data[A-1:0];
                    REG_ROLL:  angle_reg[2] <= cfg_data[A-1:0];
                    default:   ;
                endcase
            end

            case (state_reg)
                TS_IDLE: idx_reg <= '0;
                TS_X2SAVE:
                begin
                    step_reg      <= '0;
                    cos_phase_reg <= 1'b0;
                end
                TS_HDIV: step_reg <= step_reg + 3'd1;
                TS_SSAVE:
                begin
                    step_reg      <= '0;
                    cos_phase_reg <= 1'b1;
                end
                TS_STORE:
                begin
                    sin_reg[idx_reg] <= sn_out;
                    cos_reg[idx_reg] <= cs_out;
                    idx_reg          <= idx_reg + 2'd1;
                end
                default: ;
            endcase
        end
    end

    // Datapath registers of the series
    always_ff @(posedge clk)
    begin
        case (state_reg)
            TS_LOAD:
            begin
                prod_reg <= mul_p + 66'(HALF);
                q_reg    <= ang[A-1 -: 2];
                swap_reg <= swap_c;
            end
            TS_XSAVE:  x_reg <= prod_reg[RW +: 32];
            TS_X2MUL:  prod_reg <= mul_p;
            TS_X2SAVE:
            begin
                x2_reg <= prod_reg[32 +: 32];
                t_reg  <= Q32_ONE;
            end
            TS_HMUL:   prod_reg <= mul_p;
            TS_HPRE:   prod_reg <= mul_p;
            TS_HDIV:   t_reg <= Q32_ONE - {1'b0, quot};
            TS_SMUL:   prod_reg <= mul_p;
            TS_SSAVE:
            begin
                sv_reg <= prod_reg[32 +: 32];
                t_reg  <= Q32_ONE;
            end
            default: ;
        endcase
    end

    assign trig_ready = (state_reg == TS_IDLE) && !dirty_reg;
    assign yaw_sin    = sin_reg[0];
    assign yaw_cos    = cos_reg[0];
    assign pitch_sin  = sin_reg[1];
    assign pitch_cos  = cos_reg[1];
    assign roll_sin   = sin_reg[2];
    assign roll_cos   = cos_reg[2];

endmodule

`default_nettype wire

FILE: rtl/epr_rotate.sv
// ----------------------------------------------------------------------------
// Euler point rotation plane stage
// Rotates (u, v) by one angle in two register stages, carries w along.
// a = round((u*c - v*s) / 2^F), b = round((u*s + v*c) / 2^F).
// ----------------------------------------------------------------------------
`default_nettype none

module epr_rotate
    import epr_pkg::*;
#(
    parameter int IN_W           = COORD_WIDTH_DEF + 1,
    parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic signed [IN_W-1:0]             in_u,
    input  wire logic signed [IN_W-1:0]             in_v,
    input  wire logic signed [IN_W-1:0]             in_w,
    input  wire logic signed [TRIG_FRAC_BITS+1:0]   sn,
    input  wire logic signed [TRIG_FRAC_BITS+1:0]   cs,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic signed [IN_W:0]                    out_a,
    output logic signed [IN_W:0]                    out_b,
    output logic signed [IN_W:0]                    out_w
);

    localparam int F  = TRIG_FRAC_BITS;
    localparam int TW = F + 2;
    localparam int PW = IN_W + TW;
    localparam logic signed [PW:0] RND = (PW+1)'(1) <<< (F - 1);

    logic                   v1_reg;
    logic                   v2_reg;
    logic signed [PW-1:0]   p_uc_reg;
    logic signed [PW-1:0]   p_vs_reg;
    logic signed [PW-1:0]   p_us_reg;
    logic signed [PW-1:0]   p_vc_reg;
    logic signed [IN_W-1:0] w1_reg;
    logic signed [IN_W:0]   a_reg;
    logic signed [IN_W:0]   b_reg;
    logic signed [IN_W:0]   w2_reg;

    logic                   adv1;
    logic                   adv2;
    logic signed [PW:0]     sum_a;
    logic signed [PW:0]     sum_b;

    assign adv2     = !v2_reg || out_ready;
    assign adv1     = !v1_reg || adv2;
    assign in_ready = adv1;

    assign sum_a = (PW+1)'(p_uc_reg) - (PW+1)'(p_vs_reg) + RND;
    assign sum_b = (PW+1)'(p_us_reg) + (PW+1)'(p_vc_reg) + RND;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= in_valid;
            if (adv2)
                v2_reg <= v1_reg;
        end
    end

    // Products, then rounded sums
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            p_uc_reg <= in_u * cs;
            p_vs_reg <= in_v * sn;
            p_us_reg <= in_u * sn;
            p_vc_reg <= in_v * cs;
            w1_reg   <= in_w;
        end
        if (adv2)
        begin
            a_reg  <= sum_a[F +: IN_W+1];
            b_reg  <= sum_b[F +: IN_W+1];
            w2_reg <= (IN_W+1)'(w1_reg);
        end
    end

    assign out_valid = v2_reg;
    assign out_a     = a_reg;
    assign out_b     = b_reg;
    assign out_w     = w2_reg;

endmodule

`default_nettype wire

FILE: rtl/epr_checker.sv
// ----------------------------------------------------------------------------
// Euler point rotation checker
// Port-level properties of the rotator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "euler_point_rotation_assert.svh"

module epr_checker
    import epr_pkg::*;
#(
    parameter int TD_W = 96
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tready,
    input  wire logic                   m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    input  wire logic [TD_W-1:0]        m_axis_tdata,
    input  wire logic                   cfg_we,
    input  wire logic [REG_IDX_W-1:0]   cfg_addr
);

    logic angle_write;

    assign angle_write = cfg_we && ((cfg_addr == REG_ROLL) || (cfg_addr == REG_PITCH)
                                    || (cfg_addr == REG_YAW));

    // Hold a stalled result
    `EPR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
    `EPR_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))

    // Block input while sine and cosine are recomputed
    `EPR_ASSERT_NEXT(a_angle_blocks, angle_write, !s_axis_tready)
    `EPR_ASSERT_IMPL(a_angle_busy, angle_write, ##2 !s_axis_tready)

endmodule

bind euler_point_rotation epr_checker #(.TD_W(TD_W)) u_epr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr)
);

`default_nettype wire

FILE: tb/tb_euler_point_rotation.sv
// ----------------------------------------------------------------------------
// Euler point rotation testbench
// Streams points through the rotator under several pivot and angle settings,
// predicts each rotated point in the bench and compares it with the output.
// Both stream sides idle and stall at random in several phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_euler_point_rotation;
    import epr_pkg::*;

    localparam int CW   = 32;
    localparam int AW   = 16;
    localparam int FB   = 16;
    localparam int TD_W = 96;
    localparam int LATENCY = 12;
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam longint COORD_MAX = 64'sd2147483647;
    localparam longint COORD_MIN = -64'sd2147483648;

    logic            clk;
    logic            rst_n;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [TD_W-1:0] s_axis_tdata;
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [TD_W-1:0] m_axis_tdata;
    logic            cfg_we;
    logic [REG_IDX_W-1:0] cfg_addr;
    logic [CW-1:0]   cfg_data;

    // bench copy of the pivot and angle registers
    logic signed [CW-1:0] piv_x, piv_y, piv_z;
    logic [AW-1:0] roll_ang, pitch_ang, yaw_ang;

    logic [TD_W-1:0] point_q[$];
    logic [TD_W-1:0] rotated_q[$];
    logic  in_fire;
    int    idle_mode;
    int    err_cnt;
    int    points_in;
    int    points_out;
    int    settings_run;

    euler_point_rotation uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // point_x, point_y, point_z
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // rotated_x, rotated_y, rotated_z
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    // sine and cosine of a binary angle, series evaluated in Q32
    function automatic void sin_cos(input logic [AW-1:0] ang,
                                    output longint sn, output longint cs);
        int unsigned ks[5] = '{110, 72, 42, 20, 6};
        int unsigned kc[6] = '{132, 90, 56, 30, 12, 2};
        logic [63:0] one, r, x, x2, t, sv, cv;
        logic [1:0]  q;
        logic        swap;
        longint      s, c;
        begin
            one  = 64'h1_0000_0000;
            q    = ang[AW-1:AW-2];
            r    = 64'(ang[AW-3:0]);
            swap = r > 64'd8192;
            if (swap)
                r = 64'd16384 - r;
            x  = (r * 64'd6746518852 + 64'd8192) >> 14;
            x2 = (x * x) >> 32;
            t  = one;
            foreach (ks[i])
                t = one - ((x2 * t) >> 32) / ks[i];
            sv = (x * t) >> 32;
            t  = one;
            foreach (kc[i])
                t = one - ((x2 * t) >> 32) / kc[i];
            cv = t;
            s = longint'(((swap ? cv : sv) + 64'd32768) >> 16);
            c = longint'(((swap ? sv : cv) + 64'd32768) >> 16);
            case (q)
                2'd0: begin sn = s;  cs = c;  end
                2'd1: begin sn = c;  cs = -s; end
                2'd2: begin sn = -s; cs = -c; end
                default: begin sn = -c; cs = s; end
            endcase
        end
    endfunction

    // floor((u*a + v*b + half) / 2^FB), exact
    function automatic longint mix_round(input longint u, input longint a,
                                         input longint v, input longint b);
        logic signed [127:0] acc;
        begin
            acc = 128'(u) * 128'(a) + 128'(v) * 128'(b) + (128'sd1 <<< (FB - 1));
            return longint'(acc >>> FB);
        end
    endfunction

    function automatic logic [CW-1:0] clamp(input longint v);
        if (v > COORD_MAX)
            return COORD_MAX[CW-1:0];
        if (v < COORD_MIN)
            return COORD_MIN[CW-1:0];
        return v[CW-1:0];
    endfunction

    // rotate one packed point about the pivot: yaw, then pitch, then roll
    function automatic logic [TD_W-1:0] rotate_point(input logic [TD_W-1:0] pt);
        longint x, y, z, a, b, sy, cy, sp, cp, sr, cr;
        begin
            x = longint'($signed(pt[CW-1:0]))      - longint'(piv_x);
            y = longint'($signed(pt[2*CW-1:CW]))   - longint'(piv_y);
            z = longint'($signed(pt[3*CW-1:2*CW])) - longint'(piv_z);
            sin_cos(yaw_ang, sy, cy);
            sin_cos(pitch_ang, sp, cp);
            sin_cos(roll_ang, sr, cr);
            a = mix_round(x, cy, y, -sy);
            b = mix_round(x, sy, y, cy);
            x = a; y = b;
            a = mix_round(x, cp, z, sp);
            b = mix_round(x, -sp, z, cp);
            x = a; z = b;
            a = mix_round(y, cr, z, -sr);
            b = mix_round(y, sr, z, cr);
            y = a; z = b;
            return {clamp(z + piv_z), clamp(y + piv_y), clamp(x + piv_x)};
        end
    endfunction

    // drive the point stream and the receiver stall at the falling edge
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_axis_tvalid || in_fire)
            begin
                if (point_q.size() > 0 &&
                    !((idle_mode == 1 && $urandom_range(99) < 45) ||
                      (idle_mode == 3 && $urandom_range(99) < 24)))
                begin
                    s_axis_tdata  <= point_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            if (idle_mode == 2)
                m_axis_tready <= $urandom_range(99) >= 45;
            else if (idle_mode == 3)
                m_axis_tready <= $urandom_range(99) >= 24;
            else
                m_axis_tready <= 1'b1;
        end
    end

    // predict accepted points, check rotated ones
    always @(posedge clk)
    begin
        logic [TD_W-1:0] want;
        in_fire <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            rotated_q.push_back(rotate_point(s_axis_tdata));
            points_in++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            points_out++;
            if (rotated_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected item %h", m_axis_tdata);
            end
            else
            begin
                want = rotated_q.pop_front();
                for (int f = 0; f < 3; f++)
                begin
                    if (m_axis_tdata[f*CW +: CW] !== want[f*CW +: CW])
                    begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("item %0d field %0d: expected %h, got %h",
                                     points_out, f, want[f*CW +: CW],
                                     m_axis_tdata[f*CW +: CW]);
                    end
                end
            end
        end
    end

    // wait until every point has left the block, then let the pipe settle
    task automatic drain();
        while (point_q.size() > 0 || s_axis_tvalid || rotated_q.size() > 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CW-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            REG_PIVOT_X: piv_x     = val;
            REG_PIVOT_Y: piv_y     = val;
            REG_PIVOT_Z: piv_z     = val;
            REG_ROLL:    roll_ang  = val[AW-1:0];
            REG_PITCH:   pitch_ang = val[AW-1:0];
            REG_YAW:     yaw_ang   = val[AW-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        // hold off until the trig sequencer frees the input again
        if (idx inside {REG_ROLL, REG_PITCH, REG_YAW})
        begin
            repeat (2) @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
        end
    endtask

    function automatic logic [CW-1:0] rand_coord();
        int pick;
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                return $urandom;
            if (pick < 85)
                return CW'($signed($urandom_range(2097152)) - 1048576);
            return (pick < 92) ? COORD_MAX[CW-1:0] : COORD_MIN[CW-1:0];
        end
    endfunction

    function automatic logic [CW-1:0] rand_angle();
        int pick;
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                return $urandom;   // high bits beyond the angle are ignored
            return 32'(16'($urandom_range(7) * 8192 + $urandom_range(2) - 1));
        end
    endfunction

    task automatic queue_directed();
        point_q.push_back('0);
        point_q.push_back({COORD_MAX[CW-1:0], COORD_MAX[CW-1:0], COORD_MAX[CW-1:0]});
        point_q.push_back({COORD_MIN[CW-1:0], COORD_MIN[CW-1:0], COORD_MIN[CW-1:0]});
        point_q.push_back({COORD_MIN[CW-1:0], COORD_MAX[CW-1:0], COORD_MIN[CW-1:0]});
        point_q.push_back({32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000});
        point_q.push_back({32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001});
        point_q.push_back({32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_0000});
        point_q.push_back({32'h8000_0001, 32'h0000_0000, 32'h7FFF_FFFE});
    endtask

    task automatic apply_setting(input logic [CW-1:0] px, input logic [CW-1:0] py,
                                 input logic [CW-1:0] pz, input logic [CW-1:0] ra,
                                 input logic [CW-1:0] pa, input logic [CW-1:0] ya);
        write_reg(REG_PIVOT_X, px);
        write_reg(REG_PIVOT_Y, py);
        write_reg(REG_PIVOT_Z, pz);
        write_reg(REG_ROLL, ra);
        write_reg(REG_PITCH, pa);
        write_reg(REG_YAW, ya);
        // a write to an unused index must change nothing
        write_reg(REG_UNUSED, $urandom);
        settings_run++;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = REG_PIVOT_X;
        cfg_data = '0;
        in_fire = 1'b0;
        idle_mode = 0;
        err_cnt = 0;
        points_in = 0;
        points_out = 0;
        settings_run = 0;
        piv_x = '0; piv_y = '0; piv_z = '0;
        roll_ang = '0; pitch_ang = '0; yaw_ang = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset values: identity rotation about the origin
        queue_directed();
        drain();

        // quadrant edges, half quadrant and one past it
        apply_setting(32'h0001_0000, 32'hFFFE_0000, 32'h0000_0000,
                      32'd8192, 32'd8193, 32'd16384);
        queue_directed();
        drain();

        // extreme pivot and extreme angles: saturation on every axis
        apply_setting(COORD_MAX[CW-1:0], COORD_MIN[CW-1:0], COORD_MAX[CW-1:0],
                      32'h0000_7FFF, 32'hFFFF_8000, 32'h0001_2000);
        queue_directed();
        drain();

        for (int s = 0; s < 10; s++)
        begin
            if (s == 9)
                apply_setting(COORD_MIN[CW-1:0], COORD_MAX[CW-1:0], COORD_MIN[CW-1:0],
                              32'hFFFF_8000, 32'h0000_7FFF, 32'h0000_C000);
            else
                apply_setting(rand_coord(), rand_coord(), rand_coord(),
                              rand_angle(), rand_angle(), rand_angle());
            idle_mode = s % 4;
            for (int i = 0; i < 113; i++)
            begin
                point_q.push_back({rand_coord(), rand_coord(), rand_coord()});
                // let the sender pause mid-phase until the pipe is empty
                if (s == 5 && i == 56)
                    drain();
            end
            drain();
        end

        idle_mode = 0;
        drain();
        $display("rotated %0d of %0d points over %0d register settings,",
                 points_out, points_in, settings_run + 1);
        $display("with sender gaps, receiver stalls, saturation and quadrant edges");
        if (err_cnt == 0 && rotated_q.size() == 0)
            $display("tb_euler_point_rotation: clean");
        else
            $display("tb_euler_point_rotation: errors");
        $finish;
    end

    // stop a hung run
    initial
    begin
        #5000000;
        $display("timeout");
        $display("tb_euler_point_rotation: errors");
        $finish;
    end

endmodule

`default_nettype wire
